// ===== rtl/positional_list_store_defines.svh =====
// ----------------------------------------------------------------------------
// positional_list_store_defines
// Assertion macros used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define PLS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked across reset.
`define PLS_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pls_pkg.sv =====
// ----------------------------------------------------------------------------
// pls_pkg
// Types, constants and codes shared by the positional list store modules.
// ----------------------------------------------------------------------------
package pls_pkg;

   localparam int CAPACITY    = 16;
   localparam int ADDR_W      = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int POS_W       = 8;
   localparam int VAL_W       = 32;
   localparam int CMP_W       = POS_W + 1;
   localparam int COUNT_OUT_W = 7;

   typedef enum logic [1:0] {
      CMD_INSERT   = 2'd0,
      CMD_DELETE   = 2'd1,
      CMD_DUMP_FWD = 2'd2,
      CMD_DUMP_BWD = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_BADPOS = 2'd1,
      STATUS_EMPTY  = 2'd2,
      STATUS_FULL   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MV_RD,
      ST_MV_WR,
      ST_INS_WR,
      ST_RESULT,
      ST_DUMP_RD,
      ST_DUMP_OUT
   } seq_state_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [VAL_W-1:0]   value_out;
      logic                      last;
      logic [COUNT_OUT_W-1:0]    count_out;
   } rsp_type;

   typedef struct packed {
      logic              re;
      logic [ADDR_W-1:0] raddr;
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [VAL_W-1:0]  wdata;
   } ram_ctl_type;

   typedef struct packed {
      logic       load;
      status_type status;
      logic       use_rdata;
      logic       last;
   } res_ctl_type;

endpackage

// ===== rtl/pls_ram.sv =====
// ----------------------------------------------------------------------------
// pls_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module pls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/pls_seq.sv =====
// ----------------------------------------------------------------------------
// pls_seq
// Command sequencer: checks each item, steps one shared pointer adder over
// the memory to shift entries or read them out, and tracks the fill count.
// ----------------------------------------------------------------------------
module pls_seq import pls_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  req_type          req_data,
   output logic             req_stall,
   input  logic             out_free,
   input  logic [VAL_W-1:0] rdata,
   output ram_ctl_type      ram_ctl,
   output res_ctl_type      res_ctl,
   output logic [CNT_W-1:0] count
);

   seq_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  mv_ff, mv_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [ADDR_W-1:0] ins_addr_ff, ins_addr_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic              up_ff, up_in;

   logic              accept;
   logic [CMP_W-1:0]  pos9, cnt9;
   logic [CMP_W-1:0]  ins_moves, del_moves;
   logic [ADDR_W-1:0] addend, ptr_sum;

   assign accept = req_valid && !req_stall;
   assign pos9   = CMP_W'(req_data.position);
   assign cnt9   = CMP_W'(count_ff);
   assign ins_moves = cnt9 + CMP_W'(1) - pos9;
   assign del_moves = cnt9 - pos9;

   // The shared pointer unit. A move reads the source, steps one to the
   // destination, writes, then steps two the opposite way to the next source.
   assign ptr_sum = ptr_ff + addend;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mv_ff       <= mv_in;
      ptr_ff      <= ptr_in;
      ins_addr_ff <= ins_addr_in;
      val_ff      <= val_in;
      up_ff       <= up_in;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      mv_in       = mv_ff;
      ptr_in      = ptr_ff;
      ins_addr_in = ins_addr_ff;
      val_in      = val_ff;
      up_in       = up_ff;
      addend      = up_ff ? ADDR_W'(1) : '1;
      req_stall   = (state_ff != ST_IDLE) || !out_free;
      ram_ctl     = '0;
      res_ctl     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.cmd)
                  CMD_INSERT: begin
                     res_ctl.last = 1'b1;
                     if (pos9 == '0 || pos9 > cnt9 + CMP_W'(1)) begin
                        res_ctl.load   = 1'b1;
                        res_ctl.status = STATUS_BADPOS;
                     end else if (count_ff == CNT_W'(CAPACITY)) begin
                        res_ctl.load   = 1'b1;
                        res_ctl.status = STATUS_FULL;
                     end else begin
                        count_in    = count_ff + CNT_W'(1);
                        mv_in       = CNT_W'(ins_moves);
                        ptr_in      = ADDR_W'(count_ff - CNT_W'(1));
                        ins_addr_in = ADDR_W'(req_data.position - POS_W'(1));
                        val_in      = req_data.value_in;
                        up_in       = 1'b0;
                        state_in    = (ins_moves == '0) ? ST_INS_WR : ST_MV_RD;
                     end
                  end
                  CMD_DELETE: begin
                     res_ctl.last = 1'b1;
                     if (count_ff == '0) begin
                        res_ctl.load   = 1'b1;
                        res_ctl.status = STATUS_EMPTY;
                     end else if (pos9 == '0 || pos9 > cnt9) begin
                        res_ctl.load   = 1'b1;
                        res_ctl.status = STATUS_BADPOS;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                        mv_in    = CNT_W'(del_moves);
                        ptr_in   = ADDR_W'(req_data.position);
                        up_in    = 1'b1;
                        state_in = (del_moves == '0) ? ST_RESULT : ST_MV_RD;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        res_ctl.load   = 1'b1;
                        res_ctl.status = STATUS_EMPTY;
                        res_ctl.last   = 1'b1;
                     end else begin
                        mv_in    = count_ff;
                        up_in    = (req_data.cmd == CMD_DUMP_FWD);
                        ptr_in   = (req_data.cmd == CMD_DUMP_FWD) ?
                                   '0 : ADDR_W'(count_ff - CNT_W'(1));
                        state_in = ST_DUMP_RD;
                     end
                  end
               endcase
            end
         end
         ST_MV_RD: begin
            ram_ctl.re    = 1'b1;
            ram_ctl.raddr = ptr_ff;
            addend        = up_ff ? '1 : ADDR_W'(1);
            ptr_in        = ptr_sum;
            state_in      = ST_MV_WR;
         end
         ST_MV_WR: begin
            ram_ctl.we    = 1'b1;
            ram_ctl.waddr = ptr_ff;
            ram_ctl.wdata = rdata;
            addend        = up_ff ? ADDR_W'(2) : ~ADDR_W'(1);
            ptr_in        = ptr_sum;
            mv_in         = mv_ff - CNT_W'(1);
            if (mv_ff == CNT_W'(1)) begin
               state_in = up_ff ? ST_RESULT : ST_INS_WR;
            end else begin
               state_in = ST_MV_RD;
            end
         end
         ST_INS_WR: begin
            ram_ctl.we    = 1'b1;
            ram_ctl.waddr = ins_addr_ff;
            ram_ctl.wdata = val_ff;
            state_in      = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               res_ctl.load   = 1'b1;
               res_ctl.status = STATUS_OK;
               res_ctl.last   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_DUMP_RD: begin
            ram_ctl.re    = 1'b1;
            ram_ctl.raddr = ptr_ff;
            ptr_in        = ptr_sum;
            state_in      = ST_DUMP_OUT;
         end
         ST_DUMP_OUT: begin
            // The read data holds until the next read, so a stalled
            // receiver simply parks the walk here.
            if (out_free) begin
               res_ctl.load      = 1'b1;
               res_ctl.status    = STATUS_OK;
               res_ctl.use_rdata = 1'b1;
               res_ctl.last      = (mv_ff == CNT_W'(1));
               mv_in             = mv_ff - CNT_W'(1);
               if (mv_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  ram_ctl.re    = 1'b1;
                  ram_ctl.raddr = ptr_ff;
                  ptr_in        = ptr_sum;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign count = count_ff;

endmodule

// ===== rtl/positional_list_store.sv =====
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of signed 32-bit values with positional insert and delete
// and forward or backward readout.
// ----------------------------------------------------------------------------
// Usage: a command item enters on req_valid/req_stall; results leave on
// rsp_valid/rsp_stall through one output register. Insert and delete give
// one result, a dump gives one result per stored value (or one empty status),
// with last set on the final result of the item.
// An item is taken only while the sequencer is idle and the output register
// is free. Entries are shifted through the single memory port pair, each
// moved entry read in ST_MV_RD and written in ST_MV_WR; at most 15 entries
// shift for one insert or delete. A dump issues its first read in the cycle
// after the item and then gives one result per cycle while the receiver
// takes them. Rejected commands answer in the cycle after the item.
// Reset clears the fill count and the output valid flag; the list is empty.
// Stored words are not cleared and are never read before being written.
// When the receiver stalls, the output result holds and the sequencer waits.
// ----------------------------------------------------------------------------
module positional_list_store import pls_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ram_ctl_type      ram_ctl;
   res_ctl_type      res_ctl;
   logic [VAL_W-1:0] rdata;
   logic [CNT_W-1:0] count;
   logic             out_free;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   pls_ram #(
      .WIDTH (VAL_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (ram_ctl.we),
      .waddr (ram_ctl.waddr),
      .wdata (ram_ctl.wdata),
      .re    (ram_ctl.re),
      .raddr (ram_ctl.raddr),
      .rdata (rdata)
   );

   pls_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .out_free  (out_free),
      .rdata     (rdata),
      .ram_ctl   (ram_ctl),
      .res_ctl   (res_ctl),
      .count     (count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ctl.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ctl.load) begin
         rsp_data_ff.status    <= res_ctl.status;
         rsp_data_ff.value_out <= res_ctl.use_rdata ? rdata : '0;
         rsp_data_ff.last      <= res_ctl.last;
         rsp_data_ff.count_out <= COUNT_OUT_W'(count);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/pls_checker.sv =====
// ----------------------------------------------------------------------------
// pls_checker
// Port-level checks for the positional list store, bound to the top level.
// ----------------------------------------------------------------------------
`include "positional_list_store_defines.svh"

module pls_checker import pls_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   `PLS_ASSERT_RST(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "result valid after reset")

   `PLS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled result changed")

   // An accepted item either answers at once or keeps the block busy.
   `PLS_ASSERT(a_busy_after_accept, clock, reset, req_valid && !req_stall |=> rsp_valid || req_stall, "block idle with no result after an item")

   `PLS_ASSERT(a_error_is_single, clock, reset, rsp_valid && rsp_data.status != STATUS_OK |-> rsp_data.last && rsp_data.value_out == '0, "error result not a single empty result")

   `PLS_ASSERT(a_empty_count, clock, reset, rsp_valid && rsp_data.status == STATUS_EMPTY |-> rsp_data.count_out == '0 && rsp_data.count_out <= COUNT_OUT_W'(CAPACITY), "empty status with stored values")

endmodule

bind positional_list_store pls_checker u_pls_checker (.*);
